@@ rtl/uasmd_pkg.sv @@
package uasmd_pkg;

    localparam int DATA_W  = 32;
    localparam int RES_W   = 64;
    localparam int CMD_W   = 2;
    localparam int WIDTH_D = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // one pipeline slot
    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] aq;
        logic [DATA_W-1:0] divisor;
        logic [RES_W-1:0]  res;
    } stage_t;

endpackage

@@ rtl/uasmd_in_if.sv @@
interface uasmd_in_if
    import uasmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

@@ rtl/uasmd_out_if.sv @@
interface uasmd_out_if
    import uasmd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

@@ rtl/uasmd_front.sv @@
module uasmd_front
    import uasmd_pkg::*;
#(
    parameter int WIDTH = WIDTH_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output stage_t            stage
);

    localparam logic [DATA_W-1:0] MASK = DATA_W'((65'd1 << WIDTH) - 65'd1);

    logic [DATA_W-1:0] a_m;
    logic [DATA_W-1:0] b_m;
    logic [DATA_W-1:0] diff;
    logic [DATA_W:0]   sum;
    logic [RES_W-1:0]  prod;
    cmd_t              op;
    stage_t            stage_reg;
    stage_t            stage_next;

    assign a_m  = operand_a & MASK;
    assign b_m  = operand_b & MASK;
    assign op   = cmd_t'(cmd);
    assign sum  = {1'b0, a_m} + {1'b0, b_m};
    assign diff = (a_m - b_m) & MASK;
    assign prod = RES_W'(a_m) * RES_W'(b_m);

    always_comb
    begin
        stage_next.valid   = valid;
        stage_next.cmd     = op;
        stage_next.rem     = '0;
        stage_next.aq      = a_m;
        stage_next.divisor = b_m;
        unique case (op)
            CMD_ADD: stage_next.res = RES_W'(sum);
            CMD_SUB: stage_next.res = RES_W'(diff);
            CMD_MUL: stage_next.res = prod;
            CMD_DIV: stage_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

@@ rtl/uasmd_div_step.sv @@
module uasmd_div_step
    import uasmd_pkg::*;
#(
    parameter int WIDTH = WIDTH_D
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  stage_t stage_in,
    output stage_t stage_out
);

    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           ge;
    stage_t         stage_reg;
    stage_t         stage_next;

    // shift in next dividend bit, try subtracting divisor
    assign trial = {stage_in.rem[WIDTH-1:0], stage_in.aq[WIDTH-1]};
    assign diff  = trial - {1'b0, stage_in.divisor[WIDTH-1:0]};
    assign ge    = trial >= {1'b0, stage_in.divisor[WIDTH-1:0]};

    always_comb
    begin
        stage_next     = stage_in;
        stage_next.rem = ge ? DATA_W'(diff[WIDTH-1:0]) : DATA_W'(trial[WIDTH-1:0]);
        stage_next.aq  = DATA_W'({stage_in.aq[WIDTH-2:0], ge});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

@@ rtl/unsigned_add_sub_mul_div_unit.sv @@
// path: front stage register, then WIDTH division step registers; the last one drives the result
// throughput: one item per cycle while the output is not stalled; the restoring divider is unrolled into
//   WIDTH pipeline stages of one quotient bit each, so every op rides the same pipe
// a stall at the output freezes the whole pipe; nothing is dropped or repeated
// reset: asynchronous, active low, clears every stage's valid bit
module unsigned_add_sub_mul_div_unit
    import uasmd_pkg::*;
#(
    parameter int WIDTH = WIDTH_D
)
(
    input  logic clk,
    input  logic rst_n,
    uasmd_in_if.sink    req,
    uasmd_out_if.source rsp
);

    // pipe[0] is the front stage, pipe[WIDTH] the output register
    stage_t         pipe [0:WIDTH];
    logic [WIDTH:0] valids;
    logic           en;

    // global advance: move whenever the output slot is empty or being taken
    assign en        = !pipe[WIDTH].valid || rsp.ready;
    assign req.ready = en;

    // add, subtract and multiply are done up front and ride along
    uasmd_front #(
        .WIDTH (WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (req.valid),
        .cmd       (req.cmd),
        .operand_a (req.operand_a),
        .operand_b (req.operand_b),
        .stage     (pipe[0])
    );

    // one restoring division step per stage, msb of quotient first
    for (genvar i = 0; i < WIDTH; i++)
    begin : g_div
        uasmd_div_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (pipe[i]),
            .stage_out (pipe[i+1])
        );
    end

    for (genvar j = 0; j <= WIDTH; j++)
    begin : g_valid
        assign valids[j] = pipe[j].valid;
    end

    // after all steps the shifted dividend holds the quotient
    assign rsp.valid        = pipe[WIDTH].valid;
    assign rsp.result_value = (pipe[WIDTH].cmd == CMD_DIV) ?
                              RES_W'(pipe[WIDTH].aq[WIDTH-1:0]) : pipe[WIDTH].res;

    // stalled pipe holds its occupancy
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valids))
        else $error("pipe occupancy changed during stall");

    // transfer into the pipe lands in the front stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> pipe[0].valid)
        else $error("accepted item missing from front stage");

    // add result never exceeds WIDTH+1 bits
    a_add_w: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && pipe[WIDTH].cmd == CMD_ADD) |-> (rsp.result_value >> (WIDTH + 1)) == '0)
        else $error("add result too wide");

    // subtract and divide results fit WIDTH bits
    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (pipe[WIDTH].cmd == CMD_SUB || pipe[WIDTH].cmd == CMD_DIV))
        |-> (rsp.result_value >> WIDTH) == '0)
        else $error("narrow result too wide");

endmodule
